// ----- design/npcs_pkg.sv -----
// Package for the nearest palette color search: sizes, codes, item types and helpers.
`timescale 1ns / 1ps
package npcs_pkg;

  localparam int PALETTE_SIZE = 256;
  localparam int ADDR_W       = $clog2(PALETTE_SIZE);
  localparam int IDX_W        = 8;
  localparam int CHAN_W       = 8;
  localparam int DIST_W       = 10;
  localparam int RGB_W        = 3 * CHAN_W;

  localparam logic [DIST_W-1:0] DIST_BOUND = DIST_W'(255 * 3);

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_READ  = 2'd2
  } npcs_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } npcs_state_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [IDX_W-1:0]  index;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } npcs_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  found_index;
    logic [DIST_W-1:0] distance;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
  } npcs_out_t;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [DIST_W-1:0] l1_dist(input logic [RGB_W-1:0] e,
                                                input logic [RGB_W-1:0] q);
    l1_dist = DIST_W'(abs_diff(e[23:16], q[23:16]))
            + DIST_W'(abs_diff(e[15:8], q[15:8]))
            + DIST_W'(abs_diff(e[7:0], q[7:0]));
  endfunction

endpackage

// ----- design/nearest_palette_color_search_top.sv -----
// Top level of the nearest palette color search: palette memory, scan pipeline, result register.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------------
//  input    | in_valid_i / in_ready_o  | in_i  (kind, index, red, green, blue)
//  result   | out_valid_o / out_ready_i| out_o (found_index, distance, out_rgb)
//
// A nearest query scans the single-port palette memory one entry per cycle.
// Reset clears one valid flop per entry; an entry never written reads as black.
// No clearing pass follows reset: items are taken from the first cycle.
// A finished result waits in the output register; writes are still taken then,
// while a read or query holds in its last state until the register frees up.
`timescale 1ns / 1ps
module nearest_palette_color_search_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  npcs_pkg::npcs_in_t in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output npcs_pkg::npcs_out_t out_o
);
  import npcs_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_SIZE - 1);

  npcs_state_e state_q, state_d;

  logic [RGB_W-1:0]  mem_q [PALETTE_SIZE];
  logic [RGB_W-1:0]  mem_rdata_q;
  logic              vld_q [PALETTE_SIZE];
  logic              rd_vld_q;
  logic              rd_ok_q;

  logic              in_fire;
  logic              in_range;
  logic [ADDR_W-1:0] in_addr;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic              mem_re;
  logic [RGB_W-1:0]  entry_rgb;

  logic [ADDR_W-1:0] scan_addr_q;
  logic [RGB_W-1:0]  qry_rgb_q;
  logic [IDX_W-1:0]  rd_idx_q;

  logic              s1_v_q, s1_last_q;
  logic [ADDR_W-1:0] s1_idx_q;
  logic              s2_v_q, s2_last_q;
  logic [ADDR_W-1:0] s2_idx_q;
  logic [DIST_W-1:0] s2_dist_q;
  logic [RGB_W-1:0]  s2_rgb_q;

  logic [IDX_W-1:0]  best_idx_q;
  logic [DIST_W-1:0] best_dist_q;
  logic [RGB_W-1:0]  best_rgb_q;

  logic              out_valid_q;
  npcs_out_t         out_q;
  logic              out_load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_range   = (32'(in_i.index) < PALETTE_SIZE);
  assign in_addr    = ADDR_W'(in_i.index);

  assign mem_addr = (state_q == ST_SCAN) ? scan_addr_q : in_addr;
  assign mem_we   = in_fire && (in_i.kind == KIND_WRITE) && in_range;
  assign mem_re   = (in_fire && (in_i.kind == KIND_READ) && in_range) || (state_q == ST_SCAN);

  // Unwritten or out-of-range entries read as black.
  assign entry_rgb = (rd_vld_q && rd_ok_q) ? mem_rdata_q : '0;

  // Palette memory, one port, registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= {in_i.red, in_i.green, in_i.blue};
    end else if (mem_re) begin
      mem_rdata_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PALETTE_SIZE; i++) vld_q[i] <= 1'b0;
      rd_vld_q <= 1'b0;
    end else if (mem_we) begin
      vld_q[mem_addr] <= 1'b1;
    end else if (mem_re) begin
      rd_vld_q <= vld_q[mem_addr];
    end
  end

  // State machine.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_i.kind)
            KIND_QUERY: state_d = ST_SCAN;
            KIND_READ:  state_d = ST_READ;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ:  state_d = ST_DONE;
      ST_SCAN: begin
        if (scan_addr_q == LAST_ADDR) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (s2_v_q && s2_last_q) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Item context and scan address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_addr_q <= '0;
      rd_ok_q     <= 1'b0;
    end else begin
      if (in_fire) begin
        scan_addr_q <= '0;
        rd_ok_q     <= (in_i.kind == KIND_QUERY) || in_range;
      end else if (state_q == ST_SCAN) begin
        scan_addr_q <= scan_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      qry_rgb_q <= {in_i.red, in_i.green, in_i.blue};
      rd_idx_q  <= in_i.index;
    end
  end

  // Scan pipeline: address, memory data, distance, compare.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s1_last_q <= 1'b0;
      s2_v_q    <= 1'b0;
      s2_last_q <= 1'b0;
    end else begin
      s1_v_q    <= (state_q == ST_SCAN);
      s1_last_q <= (scan_addr_q == LAST_ADDR);
      s2_v_q    <= s1_v_q;
      s2_last_q <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q  <= scan_addr_q;
    s2_idx_q  <= s1_idx_q;
    s2_dist_q <= l1_dist(entry_rgb, qry_rgb_q);
    s2_rgb_q  <= entry_rgb;
  end

  // Best-so-far; a read loads it directly so both kinds leave through ST_DONE.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_idx_q  <= '0;
      best_dist_q <= DIST_BOUND;
    end else if (in_fire) begin
      best_idx_q  <= '0;
      best_dist_q <= DIST_BOUND;
    end else if (state_q == ST_READ) begin
      best_idx_q  <= rd_idx_q;
      best_dist_q <= '0;
    end else if (s2_v_q && (s2_dist_q < best_dist_q)) begin
      best_idx_q  <= IDX_W'(s2_idx_q);
      best_dist_q <= s2_dist_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      best_rgb_q <= entry_rgb;
    end else if (s2_v_q && ((s2_idx_q == '0) || (s2_dist_q < best_dist_q))) begin
      // entry 0 supplies the color when nothing beats the bound
      best_rgb_q <= s2_rgb_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.found_index <= best_idx_q;
      out_q.distance    <= best_dist_q;
      out_q.out_red     <= best_rgb_q[23:16];
      out_q.out_green   <= best_rgb_q[15:8];
      out_q.out_blue    <= best_rgb_q[7:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_last_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && s2_last_q) |-> (state_q == ST_DRAIN))
    else $error("last scan entry outside drain");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !mem_we)
    else $error("palette write while busy");

  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_dist_q <= DIST_BOUND)
    else $error("best distance above bound");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("result load did not show");

endmodule
